>>> rtl/core/idc_pkg.sv
// idc_pkg: shared widths, constants, lane result type and month offset table
// for the inclusive day count block; no dependencies
package idc_pkg;

   localparam int DAY_W    = 7;
   localparam int MONTH_W  = 7;
   localparam int YEAR_W   = 14;
   localparam int COUNT_W  = 23;
   localparam int SERIAL_W = 23;
   localparam int DIFF_W   = SERIAL_W + 2;
   localparam int MIDX_W   = 4;
   localparam int DBM_W    = 9;

   localparam int YEAR_LIMIT_DEFAULT = 9999;

   // floor(x / 100) as (x * RECIP_100) >> RECIP_SHIFT, exact for x < 43690
   localparam int RECIP_100   = 5243;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_W      = YEAR_W + RECIP_W;
   localparam int CENT_W      = PROD_W - RECIP_SHIFT;

   localparam int DAY_MAX   = 31;
   localparam int MONTH_MAX = 12;
   localparam int FEB       = 2;

   typedef struct packed {
      logic                ok;
      logic [SERIAL_W-1:0] serial;
   } lane_out_type;

   // days in the year before the first of the month
   function automatic logic [DBM_W-1:0] days_before_month(input logic [MIDX_W-1:0] m);
      logic [DBM_W-1:0] r;
      case (m)
         4'd2:    r = 9'd31;
         4'd3:    r = 9'd59;
         4'd4:    r = 9'd90;
         4'd5:    r = 9'd120;
         4'd6:    r = 9'd151;
         4'd7:    r = 9'd181;
         4'd8:    r = 9'd212;
         4'd9:    r = 9'd243;
         4'd10:   r = 9'd273;
         4'd11:   r = 9'd304;
         4'd12:   r = 9'd334;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

endpackage

>>> rtl/core/idc_lane.sv
// idc_lane: one date to its proleptic Gregorian serial day number, two stages
// depends on idc_pkg
module idc_lane #(
   parameter int YEAR_LIMIT = idc_pkg::YEAR_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic [idc_pkg::DAY_W-1:0]     day,
   input  logic [idc_pkg::MONTH_W-1:0]   month,
   input  logic [idc_pkg::YEAR_W-1:0]    year,
   output idc_pkg::lane_out_type         lane_out
);

   localparam logic [idc_pkg::RECIP_W-1:0] RECIP =
      idc_pkg::RECIP_W'(idc_pkg::RECIP_100);

   // stage a registers
   logic                              ok_ff;
   logic [idc_pkg::DAY_W-1:0]         day_ff;
   logic [idc_pkg::MIDX_W-1:0]        mon_ff;
   logic [idc_pkg::YEAR_W-1:0]        year_ff;
   logic [idc_pkg::YEAR_W-1:0]        prev_ff;
   logic [idc_pkg::PROD_W-1:0]        prevq_ff;
   logic [idc_pkg::PROD_W-1:0]        yearq_ff;

   logic                              ok_in;
   logic [idc_pkg::YEAR_W-1:0]        prev_in;
   logic [idc_pkg::PROD_W-1:0]        prevq_in;
   logic [idc_pkg::PROD_W-1:0]        yearq_in;

   // stage b
   logic [idc_pkg::CENT_W-1:0]        prev_cent;
   logic [idc_pkg::CENT_W-1:0]        year_cent;
   logic [idc_pkg::YEAR_W-1:0]        year_rem;
   logic                              leap;
   logic                              leap_add;
   logic [idc_pkg::SERIAL_W-1:0]      serial_in;
   idc_pkg::lane_out_type             out_ff;

   // range checks, previous year and reciprocal products
   always_comb begin
      ok_in = (day >= idc_pkg::DAY_W'(1)) &&
              (day <= idc_pkg::DAY_W'(idc_pkg::DAY_MAX)) &&
              (month >= idc_pkg::MONTH_W'(1)) &&
              (month <= idc_pkg::MONTH_W'(idc_pkg::MONTH_MAX)) &&
              (year != '0) &&
              ({2'b00, year} <= 16'(YEAR_LIMIT));
      prev_in  = year - idc_pkg::YEAR_W'(1);
      prevq_in = idc_pkg::PROD_W'(prev_in) * idc_pkg::PROD_W'(RECIP);
      yearq_in = idc_pkg::PROD_W'(year) * idc_pkg::PROD_W'(RECIP);
   end

   always_ff @(posedge clock) begin
      ok_ff    <= ok_in;
      day_ff   <= day;
      mon_ff   <= month[idc_pkg::MIDX_W-1:0];
      year_ff  <= year;
      prev_ff  <= prev_in;
      prevq_ff <= prevq_in;
      yearq_ff <= yearq_in;
   end

   // leap rule and closed-form day number
   always_comb begin
      prev_cent = prevq_ff[idc_pkg::PROD_W-1:idc_pkg::RECIP_SHIFT];
      year_cent = yearq_ff[idc_pkg::PROD_W-1:idc_pkg::RECIP_SHIFT];
      year_rem  = year_ff - idc_pkg::YEAR_W'(year_cent) * idc_pkg::YEAR_W'(100);
      leap      = (year_rem == '0) ? (year_cent[1:0] == 2'b00) : (year_ff[1:0] == 2'b00);
      leap_add  = leap && (mon_ff > idc_pkg::MIDX_W'(idc_pkg::FEB));
      serial_in = idc_pkg::SERIAL_W'(prev_ff) * idc_pkg::SERIAL_W'(365)
                + idc_pkg::SERIAL_W'(prev_ff >> 2)
                - idc_pkg::SERIAL_W'(prev_cent)
                + idc_pkg::SERIAL_W'(prev_cent >> 2)
                + idc_pkg::SERIAL_W'(idc_pkg::days_before_month(mon_ff))
                + idc_pkg::SERIAL_W'(leap_add)
                + idc_pkg::SERIAL_W'(day_ff);
   end

   always_ff @(posedge clock) begin
      out_ff.ok     <= ok_ff;
      out_ff.serial <= serial_in;
   end

   assign lane_out = out_ff;

endmodule

>>> rtl/core/idc_merge.sv
// idc_merge: combines the two lane day numbers into the saturated inclusive
// count and registers the result beat; depends on idc_pkg
module idc_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          beat_valid,
   input  idc_pkg::lane_out_type         first_lane,
   input  idc_pkg::lane_out_type         second_lane,
   output logic                          rsp_valid,
   output logic signed [idc_pkg::COUNT_W-1:0] rsp_day_count,
   output logic                          rsp_dates_valid
);

   localparam logic signed [idc_pkg::DIFF_W-1:0] CNT_MAX =
      idc_pkg::DIFF_W'((1 << (idc_pkg::COUNT_W - 1)) - 1);
   localparam logic signed [idc_pkg::DIFF_W-1:0] CNT_MIN =
      -idc_pkg::DIFF_W'(1 << (idc_pkg::COUNT_W - 1));

   logic signed [idc_pkg::DIFF_W-1:0]  diff;
   logic                               ok_in;
   logic signed [idc_pkg::COUNT_W-1:0] count_in;
   logic                               valid_ff;
   logic signed [idc_pkg::COUNT_W-1:0] count_ff;
   logic                               ok_ff;

   // difference plus one, clamped to the count width, zero when invalid
   always_comb begin
      ok_in = first_lane.ok && second_lane.ok;
      diff  = $signed({2'b00, second_lane.serial}) - $signed({2'b00, first_lane.serial})
            + idc_pkg::DIFF_W'(1);
      if (!ok_in) begin
         count_in = '0;
      end else if (diff > CNT_MAX) begin
         count_in = idc_pkg::COUNT_W'(CNT_MAX);
      end else if (diff < CNT_MIN) begin
         count_in = idc_pkg::COUNT_W'(CNT_MIN);
      end else begin
         count_in = diff[idc_pkg::COUNT_W-1:0];
      end
   end

   // result beat strobe and payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= beat_valid;
      end
      count_ff <= count_in;
      ok_ff    <= ok_in;
   end

   assign rsp_valid       = valid_ff;
   assign rsp_day_count   = count_ff;
   assign rsp_dates_valid = ok_ff;

endmodule

>>> rtl/core/inclusive_day_count_between_dates.sv
// inclusive_day_count_between_dates: top level, two date lanes and a merge stage
// start passes the beat valid registers beside two lane stages and one merge stage to the rsp_valid strobe
// throughput: one date pair per cycle; busy stays low, the lanes are fully pipelined
// reset clears the beat valid pipeline only; no result beat follows a start taken
// before reset; results are never held, the receiver takes each on its strobe cycle
// depends on idc_pkg, idc_lane, idc_merge
module inclusive_day_count_between_dates #(
   parameter int YEAR_LIMIT = idc_pkg::YEAR_LIMIT_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [idc_pkg::DAY_W-1:0]     req_first_day,
   input  logic [idc_pkg::MONTH_W-1:0]   req_first_month,
   input  logic [idc_pkg::YEAR_W-1:0]    req_first_year,
   input  logic [idc_pkg::DAY_W-1:0]     req_second_day,
   input  logic [idc_pkg::MONTH_W-1:0]   req_second_month,
   input  logic [idc_pkg::YEAR_W-1:0]    req_second_year,
   output logic                          rsp_valid,
   output logic signed [idc_pkg::COUNT_W-1:0] rsp_day_count,
   output logic                          rsp_dates_valid
);

   logic                  accept;
   logic                  v1_ff;
   logic                  v2_ff;
   idc_pkg::lane_out_type first_lane;
   idc_pkg::lane_out_type second_lane;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // beat valid pipeline alongside the lane stages
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   idc_lane #(.YEAR_LIMIT(YEAR_LIMIT)) u_first_lane (
      .clock    (clock),
      .day      (req_first_day),
      .month    (req_first_month),
      .year     (req_first_year),
      .lane_out (first_lane)
   );

   idc_lane #(.YEAR_LIMIT(YEAR_LIMIT)) u_second_lane (
      .clock    (clock),
      .day      (req_second_day),
      .month    (req_second_month),
      .year     (req_second_year),
      .lane_out (second_lane)
   );

   idc_merge u_merge (
      .clock           (clock),
      .reset           (reset),
      .beat_valid      (v2_ff),
      .first_lane      (first_lane),
      .second_lane     (second_lane),
      .rsp_valid       (rsp_valid),
      .rsp_day_count   (rsp_day_count),
      .rsp_dates_valid (rsp_dates_valid)
   );

   // every accepted beat gives a result strobe
   a_beat_out: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_valid)
      else $error("accepted beat produced no result");

   // no result without an accepted beat
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !accept |-> ##3 !rsp_valid)
      else $error("result beat without an accepted request");

   // invalid pairs report a zero count
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_dates_valid) |-> (rsp_day_count == '0))
      else $error("invalid date pair with nonzero count");

   // equal dates count one day when valid
   a_same_date: assert property (@(posedge clock) disable iff (reset)
      (accept && req_first_day == req_second_day && req_first_month == req_second_month
       && req_first_year == req_second_year)
      |-> ##3 (!rsp_dates_valid || rsp_day_count == idc_pkg::COUNT_W'(1)))
      else $error("equal dates did not count one day");

endmodule

>>> bench/tb_inclusive_day_count_between_dates.sv
// tb_inclusive_day_count_between_dates: self-checking bench for the inclusive day count block
// drives date pairs on the start/busy handshake, predicts each count and checks every strobe
// depends on idc_pkg and inclusive_day_count_between_dates
module tb_inclusive_day_count_between_dates;

   localparam int COUNT_W      = idc_pkg::COUNT_W;
   localparam int YEAR_LIMIT   = idc_pkg::YEAR_LIMIT_DEFAULT;
   localparam int RANDOM_PAIRS = 900;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 60000;
   localparam int PRINT_LIMIT  = 60;

   typedef struct packed {
      logic [idc_pkg::DAY_W-1:0]   first_day;
      logic [idc_pkg::MONTH_W-1:0] first_month;
      logic [idc_pkg::YEAR_W-1:0]  first_year;
      logic [idc_pkg::DAY_W-1:0]   second_day;
      logic [idc_pkg::MONTH_W-1:0] second_month;
      logic [idc_pkg::YEAR_W-1:0]  second_year;
      logic                        drain_before;
   } date_pair_type;

   typedef struct packed {
      logic signed [COUNT_W-1:0] count;
      logic                      valid;
   } day_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [idc_pkg::DAY_W-1:0]   req_first_day    = '0;
   logic [idc_pkg::MONTH_W-1:0] req_first_month  = '0;
   logic [idc_pkg::YEAR_W-1:0]  req_first_year   = '0;
   logic [idc_pkg::DAY_W-1:0]   req_second_day   = '0;
   logic [idc_pkg::MONTH_W-1:0] req_second_month = '0;
   logic [idc_pkg::YEAR_W-1:0]  req_second_year  = '0;
   logic                        rsp_valid;
   logic signed [COUNT_W-1:0]   rsp_day_count;
   logic                        rsp_dates_valid;

   date_pair_type  pending_pairs[$];
   day_result_type expected_counts[$];
   logic        took_beat = 1'b0;
   int          pairs_sent = 0;
   int          total_pairs = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;

   inclusive_day_count_between_dates uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_first_day    (req_first_day),
      .req_first_month  (req_first_month),
      .req_first_year   (req_first_year),
      .req_second_day   (req_second_day),
      .req_second_month (req_second_month),
      .req_second_year  (req_second_year),
      .rsp_valid        (rsp_valid),
      .rsp_day_count    (rsp_day_count),
      .rsp_dates_valid  (rsp_dates_valid)
   );

   // clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // gregorian leap rule
   function automatic bit is_leap_year(int unsigned y);
      if (y % 400 == 0) return 1'b1;
      if (y % 100 == 0) return 1'b0;
      return (y % 4 == 0);
   endfunction

   // days of a common year that precede the first of month m
   function automatic int unsigned days_ahead_of_month(int unsigned m);
      int unsigned r;
      case (m)
         2:       r = 31;
         3:       r = 59;
         4:       r = 90;
         5:       r = 120;
         6:       r = 151;
         7:       r = 181;
         8:       r = 212;
         9:       r = 243;
         10:      r = 273;
         11:      r = 304;
         12:      r = 334;
         default: r = 0;
      endcase
      return r;
   endfunction

   function automatic bit date_in_range(int unsigned d, int unsigned m, int unsigned y);
      return d >= 1 && d <= 31 && m >= 1 && m <= 12 && y >= 1 && y <= YEAR_LIMIT;
   endfunction

   // serial day number, day 1 of year 1 is 1
   function automatic longint serial_day_number(int unsigned d, int unsigned m, int unsigned y);
      longint      n;
      int unsigned prior;
      prior = y - 1;
      n = longint'(prior) * 365 + prior / 4 - prior / 100 + prior / 400;
      n += days_ahead_of_month(m);
      if (m > 2 && is_leap_year(y)) n += 1;
      return n + d;
   endfunction

   function automatic day_result_type predict_day_count(date_pair_type p);
      day_result_type r;
      longint      span;
      longint      top;
      top = (longint'(1) <<< (COUNT_W - 1)) - 1;
      span = 0;
      r.valid = date_in_range(p.first_day, p.first_month, p.first_year) &&
                date_in_range(p.second_day, p.second_month, p.second_year);
      if (r.valid) begin
         span = serial_day_number(p.second_day, p.second_month, p.second_year)
              - serial_day_number(p.first_day, p.first_month, p.first_year) + 1;
         if (span > top) span = top;
         if (span < -top - 1) span = -top - 1;
      end
      r.count = span[COUNT_W-1:0];
      return r;
   endfunction

   task automatic add_pair(input int d1, input int m1, input int y1,
                           input int d2, input int m2, input int y2, input bit drain);
      date_pair_type p;
      p.first_day    = idc_pkg::DAY_W'(d1);
      p.first_month  = idc_pkg::MONTH_W'(m1);
      p.first_year   = idc_pkg::YEAR_W'(y1);
      p.second_day   = idc_pkg::DAY_W'(d2);
      p.second_month = idc_pkg::MONTH_W'(m2);
      p.second_year  = idc_pkg::YEAR_W'(y2);
      p.drain_before = drain;
      pending_pairs.push_back(p);
   endtask

   // years around the leap rule and the ends of the range
   function automatic int pick_edge_year();
      int r;
      case ($urandom_range(11))
         0:       r = 1;
         1:       r = 4;
         2:       r = 100;
         3:       r = 400;
         4:       r = 1600;
         5:       r = 1900;
         6:       r = 2000;
         7:       r = 2100;
         8:       r = 2400;
         9:       r = 9996;
         10:      r = YEAR_LIMIT;
         default: r = $urandom_range(2499, 1) * 4;
      endcase
      return r;
   endfunction

   function automatic int clip_year(int y);
      if (y < 1) return 1;
      if (y > YEAR_LIMIT) return YEAR_LIMIT;
      return y;
   endfunction

   function automatic date_pair_type make_random_pair();
      date_pair_type p;
      int         kind;
      int         y;
      kind = $urandom_range(99);
      p.drain_before = 1'b0;
      p.first_day    = idc_pkg::DAY_W'($urandom_range(31, 1));
      p.first_month  = idc_pkg::MONTH_W'($urandom_range(12, 1));
      p.first_year   = idc_pkg::YEAR_W'($urandom_range(YEAR_LIMIT, 1));
      p.second_day   = idc_pkg::DAY_W'($urandom_range(31, 1));
      p.second_month = idc_pkg::MONTH_W'($urandom_range(12, 1));
      p.second_year  = idc_pkg::YEAR_W'($urandom_range(YEAR_LIMIT, 1));
      if (kind < 45) begin
         // two valid dates anywhere in range
      end else if (kind < 70) begin
         // nearby years, either order
         y = $urandom_range(1) ? pick_edge_year() : $urandom_range(YEAR_LIMIT, 1);
         p.first_year  = idc_pkg::YEAR_W'(y);
         p.second_year = idc_pkg::YEAR_W'(clip_year(y + $urandom_range(2) - 1));
      end else if (kind < 80) begin
         // around the end of february
         y = pick_edge_year();
         p.first_year   = idc_pkg::YEAR_W'(y);
         p.second_year  = idc_pkg::YEAR_W'(clip_year(y + $urandom_range(1)));
         p.first_month  = idc_pkg::MONTH_W'($urandom_range(3, 2));
         p.second_month = idc_pkg::MONTH_W'($urandom_range(3, 2));
         p.first_day    = idc_pkg::DAY_W'($urandom_range(31, 27));
         p.second_day   = idc_pkg::DAY_W'($urandom_range(31, 1));
      end else if (kind < 90) begin
         // one field out of range
         case ($urandom_range(5))
            0: p.first_day    = idc_pkg::DAY_W'($urandom_range(1) ? 0 :
                                                $urandom_range(127, 32));
            1: p.first_month  = idc_pkg::MONTH_W'($urandom_range(1) ? 0 :
                                                  $urandom_range(127, 13));
            2: p.first_year   = idc_pkg::YEAR_W'($urandom_range(1) ? 0 :
                                                 $urandom_range(16383, YEAR_LIMIT + 1));
            3: p.second_day   = idc_pkg::DAY_W'($urandom_range(1) ? 0 :
                                                $urandom_range(127, 32));
            4: p.second_month = idc_pkg::MONTH_W'($urandom_range(1) ? 0 :
                                                  $urandom_range(127, 13));
            default: p.second_year = idc_pkg::YEAR_W'($urandom_range(1) ? 0 :
                                     $urandom_range(16383, YEAR_LIMIT + 1));
         endcase
      end else begin
         // raw bits on every field
         p.first_day    = idc_pkg::DAY_W'($urandom);
         p.first_month  = idc_pkg::MONTH_W'($urandom);
         p.first_year   = idc_pkg::YEAR_W'($urandom);
         p.second_day   = idc_pkg::DAY_W'($urandom);
         p.second_month = idc_pkg::MONTH_W'($urandom);
         p.second_year  = idc_pkg::YEAR_W'($urandom);
      end
      return p;
   endfunction

   // sender idle rate per third of the run
   function automatic int idle_percent(int sent);
      if (sent < total_pairs / 3) return 21;
      if (sent < 2 * total_pairs / 3) return 52;
      return 0;
   endfunction

   // stimulus, reset and end of run
   initial begin
      date_pair_type p;
      // equal dates, full span both ways, one day back
      add_pair(1, 1, 1, 1, 1, 1, 1'b0);
      add_pair(1, 1, 1, 31, 12, YEAR_LIMIT, 1'b0);
      add_pair(31, 12, YEAR_LIMIT, 1, 1, 1, 1'b0);
      add_pair(15, 6, 2020, 14, 6, 2020, 1'b0);
      // leap rule: 400-year, century, plain leap, common year
      add_pair(28, 2, 2000, 1, 3, 2000, 1'b0);
      add_pair(28, 2, 1900, 1, 3, 1900, 1'b0);
      add_pair(28, 2, 2024, 29, 2, 2024, 1'b0);
      add_pair(1, 1, 2024, 29, 2, 2024, 1'b0);
      add_pair(29, 2, 2023, 1, 3, 2024, 1'b0);
      add_pair(31, 12, 1999, 1, 1, 2000, 1'b0);
      // day past the length of its month
      add_pair(31, 4, 2023, 1, 5, 2023, 1'b0);
      add_pair(1, 2, 2023, 30, 2, 2023, 1'b0);
      // out of range fields, including all bits set
      add_pair(0, 1, 2000, 1, 1, 2000, 1'b0);
      add_pair(32, 1, 2000, 1, 1, 2000, 1'b0);
      add_pair(127, 127, 16383, 127, 127, 16383, 1'b0);
      add_pair(1, 0, 2000, 1, 1, 2000, 1'b0);
      add_pair(1, 13, 2000, 1, 1, 2000, 1'b0);
      add_pair(1, 1, 0, 1, 1, 2000, 1'b0);
      add_pair(1, 1, YEAR_LIMIT + 1, 1, 1, 2000, 1'b0);
      add_pair(1, 1, 2000, 0, 1, 2000, 1'b0);
      add_pair(1, 1, 2000, 99, 1, 2000, 1'b0);
      add_pair(1, 1, 2000, 1, 99, 2000, 1'b0);
      add_pair(1, 1, 2000, 1, 1, 0, 1'b0);
      add_pair(1, 1, 2000, 1, 1, 16383, 1'b0);
      // random part, draining the pipe now and then
      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         p = make_random_pair();
         p.drain_before = (i % 250 == 0);
         pending_pairs.push_back(p);
      end
      total_pairs = pending_pairs.size();

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_pairs.size() != 0 || start || expected_counts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("RESULT: ERROR");
      $finish;
   end

   // driver: present the next pair at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (took_beat) begin
            pending_pairs.delete(0);
            pairs_sent = pairs_sent + 1;
         end
         if (start && !took_beat) begin
            // beat not taken yet, hold it
         end else if (pending_pairs.size() == 0) begin
            start <= 1'b0;
         end else if (pending_pairs[0].drain_before && expected_counts.size() != 0) begin
            start <= 1'b0;
         end else if ($urandom_range(99) < idle_percent(pairs_sent)) begin
            start <= 1'b0;
         end else begin
            start            <= 1'b1;
            req_first_day    <= pending_pairs[0].first_day;
            req_first_month  <= pending_pairs[0].first_month;
            req_first_year   <= pending_pairs[0].first_year;
            req_second_day   <= pending_pairs[0].second_day;
            req_second_month <= pending_pairs[0].second_month;
            req_second_year  <= pending_pairs[0].second_year;
         end
      end
   end

   // monitor: predict accepted beats, check each result strobe
   always @(posedge clock) begin : monitor
      date_pair_type  seen;
      day_result_type want;
      if (reset) begin
         took_beat <= 1'b0;
      end else begin
         took_beat <= start && !busy;
         if (start && !busy) begin
            seen.first_day    = req_first_day;
            seen.first_month  = req_first_month;
            seen.first_year   = req_first_year;
            seen.second_day   = req_second_day;
            seen.second_month = req_second_month;
            seen.second_year  = req_second_year;
            seen.drain_before = 1'b0;
            expected_counts.push_back(predict_day_count(seen));
         end
         if (rsp_valid) begin
            if (expected_counts.size() == 0) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= PRINT_LIMIT)
                  $display("%0t unexpected result: expected none, got count %0d valid %0b",
                           $time, rsp_day_count, rsp_dates_valid);
            end else begin
               want = expected_counts.pop_front();
               if (rsp_day_count !== want.count) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= PRINT_LIMIT)
                     $display("%0t day_count mismatch: expected %0d, got %0d",
                              $time, want.count, rsp_day_count);
               end
               if (rsp_dates_valid !== want.valid) begin
                  mismatch_count = mismatch_count + 1;
                  if (mismatch_count <= PRINT_LIMIT)
                     $display("%0t dates_valid mismatch: expected %0b, got %0b",
                              $time, want.valid, rsp_dates_valid);
               end
            end
         end
      end
   end

endmodule
